/* sv/tvsa_pkg.sv */
// Package for the timed voice slot allocator.
// Holds the slot count, derived widths, the queued item type and the back-end states.
// No dependencies.
package tvsa_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W       = 16;
  localparam int SLOT_W      = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = 16'hFFFF;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_PLAY = 1'b1;

  // result kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STOP  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [CNT_W-1:0] duration;
    logic [15:0]      sound_id;
  } item_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_FLUSH,
    ST_FIND,
    ST_STEAL,
    ST_PLAY
  } state_e;

endpackage

/* sv/timed_voice_slot_allocator.sv */
// Voice slot allocator with stealing. Items queue in a two-entry front end.
// An item passes through the back end as a pop, a scan reading each slot in turn,
// then a flush (tick) or a play write, with a steal result first when a play steals.
// Results appear one per cycle on valid_o, registered; the receiver cannot stall.
// Asynchronous active-low reset clears all countdowns (every slot free) and the queue.
module timed_voice_slot_allocator
  import tvsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cmd_i,
  input  logic [15:0]       duration_i,
  input  logic [15:0]       sound_id_i,
  output logic              valid_o,
  output logic              kind_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [15:0]       sound_out_o,
  output logic              last_o
);

  item_t in_item;
  head_t head;
  logic  pop;

  assign in_item.cmd      = cmd_i;
  assign in_item.duration = duration_i;
  assign in_item.sound_id = sound_id_i;

  tvsa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (in_item),
    .head_o (head),
    .pop_i  (pop)
  );

  tvsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .kind_o      (kind_o),
    .slot_o      (slot_o),
    .sound_out_o (sound_out_o),
    .last_o      (last_o)
  );

endmodule

/* sv/tvsa_front.sv */
// Front end: takes command items and queues them for the back end.
// Depends on tvsa_pkg.
module tvsa_front
  import tvsa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  item_t item_i,
  output head_t head_o,
  input  logic  pop_i
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign busy = (count_q == QCNT_W'(QDEPTH));
  assign push = start && !busy;
  assign pop  = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_i;
  end

endmodule

/* sv/tvsa_back.sv */
// Back end: slot countdown table and the scan sequencer for ticks and play requests.
// Depends on tvsa_pkg; fed by tvsa_front.
module tvsa_back
  import tvsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  head_t             head_i,
  output logic              pop_o,
  output logic              valid_o,
  output logic              kind_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [15:0]       sound_out_o,
  output logic              last_o
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  item_t             item_q, item_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  tgt_q, tgt_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_slot_q, pend_slot_d;
  logic [RES_W-1:0]  nres_q, nres_d;

  logic [CNT_W-1:0]  rem_q [SLOTS];
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [CNT_W-1:0]  wdata;
  logic [CNT_W-1:0]  cur;
  logic              last_idx;

  logic              valid_d, kind_d, last_d;
  logic [SLOT_W-1:0] slot_d;
  logic [15:0]       sound_d;
  logic              valid_q, kind_q, last_q;
  logic [SLOT_W-1:0] slot_q;
  logic [15:0]       sound_q;

  assign cur      = rem_q[idx_q];
  assign last_idx = (idx_q == IDX_W'(SLOTS - 1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    item_d      = item_q;
    found_d     = found_q;
    tgt_d       = tgt_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    nres_d      = nres_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '0;
    valid_d     = 1'b0;
    kind_d      = KIND_STOP;
    slot_d      = '0;
    sound_d     = '0;
    last_d      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o      = 1'b1;
          item_d     = head_i.item;
          idx_d      = '0;
          found_d    = 1'b0;
          tgt_d      = '0;
          best_d     = FULL_COUNT;
          best_idx_d = '0;
          pend_d     = 1'b0;
          nres_d     = '0;
          state_d    = (head_i.item.cmd == CMD_PLAY) ? ST_FIND : ST_TICK;
        end
      end
      ST_TICK: begin
        if (cur != '0) begin
          we    = 1'b1;
          wdata = cur - 1'b1;
          if (cur == CNT_W'(1) && nres_q < RES_W'(MAX_RESULTS)) begin
            // previous expiry goes out now; this one waits to learn if it is the last
            if (pend_q) begin
              valid_d = 1'b1;
              slot_d  = SLOT_W'(pend_slot_q);
            end
            pend_d      = 1'b1;
            pend_slot_d = idx_q;
            nres_d      = nres_q + 1'b1;
          end
        end
        if (last_idx) state_d = ST_FLUSH;
        else          idx_d   = idx_q + 1'b1;
      end
      ST_FLUSH: begin
        if (pend_q) begin
          valid_d = 1'b1;
          slot_d  = SLOT_W'(pend_slot_q);
          last_d  = 1'b1;
        end
        pend_d  = 1'b0;
        state_d = ST_IDLE;
      end
      ST_FIND: begin
        if (cur == '0 && !found_q) begin
          found_d = 1'b1;
          tgt_d   = idx_q;
        end
        if (cur < best_q) begin
          best_d     = cur;
          best_idx_d = idx_q;
        end
        if (last_idx) state_d = found_d ? ST_PLAY : ST_STEAL;
        else          idx_d   = idx_q + 1'b1;
      end
      ST_STEAL: begin
        valid_d = 1'b1;
        slot_d  = SLOT_W'(best_idx_q);
        tgt_d   = best_idx_q;
        state_d = ST_PLAY;
      end
      ST_PLAY: begin
        we      = 1'b1;
        waddr   = tgt_q;
        wdata   = item_q.duration;
        valid_d = 1'b1;
        kind_d  = KIND_START;
        slot_d  = SLOT_W'(tgt_q);
        sound_d = item_q.sound_id;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      nres_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      nres_q  <= nres_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    item_q      <= item_d;
    tgt_q       <= tgt_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    pend_slot_q <= pend_slot_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    sound_q     <= sound_d;
    last_q      <= last_d;
  end

  // countdown table, cleared at reset so every slot starts free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) rem_q[i] <= '0;
    end else if (we) begin
      rem_q[waddr] <= wdata;
    end
  end

  assign valid_o     = valid_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_q;
  assign sound_out_o = sound_q;
  assign last_o      = last_q;

endmodule
